// ===== hw/rtl/smx_pkg.sv =====
`default_nettype none
package smx_pkg;

	localparam int STACK_DEPTH_DEF = 64;
	localparam int WORD_W = 32;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_OVER   = 3'd1;
	localparam logic [2:0] ST_UNDER  = 3'd2;
	localparam logic [2:0] ST_DIVZ   = 3'd3;
	localparam logic [2:0] ST_BADIDX = 3'd4;
	localparam logic [2:0] ST_HALT   = 3'd5;

	localparam logic [5:0] OP_PUSH   = 6'd0;
	localparam logic [5:0] OP_POP    = 6'd1;
	localparam logic [5:0] OP_POP2   = 6'd2;
	localparam logic [5:0] OP_ADD    = 6'd3;
	localparam logic [5:0] OP_SUB    = 6'd4;
	localparam logic [5:0] OP_MUL    = 6'd5;
	localparam logic [5:0] OP_DIV    = 6'd6;
	localparam logic [5:0] OP_DUP    = 6'd7;
	localparam logic [5:0] OP_SWAP   = 6'd8;
	localparam logic [5:0] OP_EQ     = 6'd9;
	localparam logic [5:0] OP_NE     = 6'd10;
	localparam logic [5:0] OP_GT     = 6'd11;
	localparam logic [5:0] OP_GE     = 6'd12;
	localparam logic [5:0] OP_LT     = 6'd13;
	localparam logic [5:0] OP_LE     = 6'd14;
	localparam logic [5:0] OP_NEG    = 6'd15;
	localparam logic [5:0] OP_INC    = 6'd16;
	localparam logic [5:0] OP_DEC    = 6'd17;
	localparam logic [5:0] OP_PRINT  = 6'd18;
	localparam logic [5:0] OP_READ   = 6'd19;
	localparam logic [5:0] OP_CM1    = 6'd20;
	localparam logic [5:0] OP_C0     = 6'd21;
	localparam logic [5:0] OP_C5     = 6'd26;
	localparam logic [5:0] OP_CLEAR  = 6'd27;
	localparam logic [5:0] OP_INCALL = 6'd28;
	localparam logic [5:0] OP_DECALL = 6'd29;
	localparam logic [5:0] OP_FLIP   = 6'd30;
	localparam logic [5:0] OP_ISWAP  = 6'd31;
	localparam logic [5:0] OP_IDUP   = 6'd32;
	localparam logic [5:0] OP_NOP    = 6'd33;
	localparam logic [5:0] OP_STOP   = 6'd34;

	typedef struct packed {
		logic [5:0]         cmd;
		logic signed [31:0] operand;
	} cmd_item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic               shown_valid;
		logic signed [31:0] shown_value;
		logic [6:0]         stack_depth;
	} rsp_item_t;

	typedef struct packed {
		logic load;
		logic dec;
		logic exec;
		logic div_step;
		logic div_wr;
		logic wr2;
		logic sw_rd;
		logic sw_wr;
		logic sw_wr2;
		logic fin;
	} dp_ctl_t;

	typedef struct packed {
		logic refuse;
		logic go_div;
		logic go_wr2;
		logic go_sweep;
		logic is_flip;
		logic div_last;
		logic more_incdec;
		logic more_flip;
		logic rsp_free;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/smx_ram.sv =====
`default_nettype none
module smx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     ren,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (ren) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/smx_ctrl.sv =====
`default_nettype none
module smx_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cmd_valid,
	input  wire smx_pkg::dp_stat_t stat,
	output smx_pkg::dp_ctl_t      ctl,
	output logic                  idle
);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_DEC    = 10'b00_0000_0010,
		S_EXEC   = 10'b00_0000_0100,
		S_DIV    = 10'b00_0000_1000,
		S_DWR    = 10'b00_0001_0000,
		S_WR2    = 10'b00_0010_0000,
		S_SW_RD  = 10'b00_0100_0000,
		S_SW_WR  = 10'b00_1000_0000,
		S_SW_WR2 = 10'b01_0000_0000,
		S_FIN    = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_nxt;

	always_comb begin
		ctl = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					ctl.load = 1'b1;
					state_nxt = S_DEC;
				end
			end
			S_DEC: begin
				ctl.dec = 1'b1;
				state_nxt = stat.refuse ? S_FIN : S_EXEC;
			end
			S_EXEC: begin
				ctl.exec = 1'b1;
				if (stat.go_div) begin
					state_nxt = S_DIV;
				end else if (stat.go_wr2) begin
					state_nxt = S_WR2;
				end else if (stat.go_sweep) begin
					state_nxt = S_SW_RD;
				end else begin
					state_nxt = S_FIN;
				end
			end
			S_DIV: begin
				ctl.div_step = 1'b1;
				if (stat.div_last) begin
					state_nxt = S_DWR;
				end
			end
			S_DWR: begin
				ctl.div_wr = 1'b1;
				state_nxt = S_FIN;
			end
			S_WR2: begin
				ctl.wr2 = 1'b1;
				state_nxt = S_FIN;
			end
			S_SW_RD: begin
				ctl.sw_rd = 1'b1;
				state_nxt = S_SW_WR;
			end
			S_SW_WR: begin
				ctl.sw_wr = 1'b1;
				if (stat.is_flip) begin
					state_nxt = S_SW_WR2;
				end else if (stat.more_incdec) begin
					state_nxt = S_SW_RD;
				end else begin
					state_nxt = S_FIN;
				end
			end
			S_SW_WR2: begin
				ctl.sw_wr2 = 1'b1;
				state_nxt = stat.more_flip ? S_SW_RD : S_FIN;
			end
			S_FIN: begin
				if (stat.rsp_free) begin
					ctl.fin = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	assign idle = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/smx_dp.sv =====
`default_nettype none
module smx_dp #(
	parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire smx_pkg::cmd_item_t  cmd_item,
	input  wire logic                rsp_stall,
	input  wire smx_pkg::dp_ctl_t    ctl,
	output smx_pkg::dp_stat_t        stat,
	output logic                     rsp_valid,
	output smx_pkg::rsp_item_t       rsp_item
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int DW = $clog2(STACK_DEPTH + 1);

	logic [5:0]    cmd_q;
	logic [31:0]   opnd_q;
	logic [DW-1:0] depth_q;
	logic          halted_q;
	logic [2:0]    st_q;
	logic          sv_q;
	logic [31:0]   shown_q;
	logic [AW-1:0] w2_addr_q;
	logic [31:0]   w2_data_q;
	logic [AW-1:0] lo_q, hi_q;
	logic [31:0]   rem_q, quo_q, dvs_q;
	logic          qneg_q;
	logic [4:0]    cnt_q;
	logic          rsp_valid_q;
	smx_pkg::rsp_item_t rsp_q;

	logic [31:0]   top, nxt;
	logic [DW-1:0] dm1, dm2;
	logic          under1, under2, full, idx_ok, is_push, is_bin, is_arith_bin;
	logic [2:0]    st_dec;
	logic [31:0]   push_val, bin_res, top_abs, nxt_abs;
	logic          we, ren;
	logic [AW-1:0] waddr, raddr_a, raddr_b;
	logic [31:0]   wdata;
	logic [32:0]   trial;

	assign dm1 = depth_q - DW'(1);
	assign dm2 = depth_q - DW'(2);
	assign under1 = (depth_q == '0);
	assign under2 = (depth_q < DW'(2));
	assign full = (depth_q >= DW'(STACK_DEPTH));
	assign idx_ok = !opnd_q[31] && (opnd_q < 32'(depth_q));
	assign is_push = (cmd_q == smx_pkg::OP_PUSH)
		|| (cmd_q >= smx_pkg::OP_CM1 && cmd_q <= smx_pkg::OP_C5);
	assign is_bin = (cmd_q >= smx_pkg::OP_ADD && cmd_q <= smx_pkg::OP_DIV)
		|| (cmd_q >= smx_pkg::OP_EQ && cmd_q <= smx_pkg::OP_LE);
	assign is_arith_bin = is_bin && (cmd_q != smx_pkg::OP_DIV);

	// refusal checks, underflow ahead of overflow
	always_comb begin
		st_dec = smx_pkg::ST_OK;
		if (halted_q) begin
			st_dec = smx_pkg::ST_HALT;
		end else if (is_push) begin
			if (full) st_dec = smx_pkg::ST_OVER;
		end else if (cmd_q == smx_pkg::OP_POP || cmd_q == smx_pkg::OP_PRINT
			|| cmd_q == smx_pkg::OP_NEG || cmd_q == smx_pkg::OP_INC
			|| cmd_q == smx_pkg::OP_DEC || cmd_q == smx_pkg::OP_READ) begin
			if (under1) st_dec = smx_pkg::ST_UNDER;
		end else if (cmd_q == smx_pkg::OP_POP2 || is_bin || cmd_q == smx_pkg::OP_SWAP) begin
			if (under2) st_dec = smx_pkg::ST_UNDER;
		end else if (cmd_q == smx_pkg::OP_DUP) begin
			if (under1) st_dec = smx_pkg::ST_UNDER;
			else if (full) st_dec = smx_pkg::ST_OVER;
		end else if (cmd_q == smx_pkg::OP_ISWAP) begin
			if (!idx_ok) st_dec = smx_pkg::ST_BADIDX;
		end else if (cmd_q == smx_pkg::OP_IDUP) begin
			if (!idx_ok) st_dec = smx_pkg::ST_BADIDX;
			else if (full) st_dec = smx_pkg::ST_OVER;
		end
	end

	assign push_val = (cmd_q == smx_pkg::OP_PUSH) ? opnd_q
		: (32'(cmd_q) - 32'(smx_pkg::OP_C0));

	always_comb begin
		case (cmd_q)
			smx_pkg::OP_ADD: bin_res = top + nxt;
			smx_pkg::OP_SUB: bin_res = top - nxt;
			smx_pkg::OP_MUL: bin_res = top * nxt;
			smx_pkg::OP_EQ:  bin_res = 32'(top == nxt);
			smx_pkg::OP_NE:  bin_res = 32'(top != nxt);
			smx_pkg::OP_GT:  bin_res = 32'($signed(top) > $signed(nxt));
			smx_pkg::OP_GE:  bin_res = 32'($signed(top) >= $signed(nxt));
			smx_pkg::OP_LT:  bin_res = 32'($signed(top) < $signed(nxt));
			default:         bin_res = 32'($signed(top) <= $signed(nxt));
		endcase
	end

	assign top_abs = top[31] ? (32'd0 - top) : top;
	assign nxt_abs = nxt[31] ? (32'd0 - nxt) : nxt;
	assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

	// stack memory port selection
	assign ren = ctl.dec || ctl.sw_rd;
	assign raddr_a = ctl.sw_rd ? lo_q : dm1[AW-1:0];
	assign raddr_b = ctl.sw_rd ? hi_q
		: ((cmd_q == smx_pkg::OP_ISWAP || cmd_q == smx_pkg::OP_IDUP)
			? opnd_q[AW-1:0] : dm2[AW-1:0]);

	always_comb begin
		we = 1'b0;
		waddr = dm1[AW-1:0];
		wdata = top;
		if (ctl.exec) begin
			if (is_push) begin
				we = 1'b1;
				waddr = depth_q[AW-1:0];
				wdata = push_val;
			end else if (is_arith_bin) begin
				we = 1'b1;
				waddr = dm2[AW-1:0];
				wdata = bin_res;
			end else if (cmd_q == smx_pkg::OP_DUP) begin
				we = 1'b1;
				waddr = depth_q[AW-1:0];
				wdata = top;
			end else if (cmd_q == smx_pkg::OP_SWAP) begin
				we = 1'b1;
				wdata = nxt;
			end else if (cmd_q == smx_pkg::OP_NEG) begin
				we = 1'b1;
				wdata = 32'd0 - top;
			end else if (cmd_q == smx_pkg::OP_INC) begin
				we = 1'b1;
				wdata = top + 32'd1;
			end else if (cmd_q == smx_pkg::OP_DEC) begin
				we = 1'b1;
				wdata = top - 32'd1;
			end else if (cmd_q == smx_pkg::OP_ISWAP) begin
				we = 1'b1;
				waddr = opnd_q[AW-1:0];
				wdata = top;
			end else if (cmd_q == smx_pkg::OP_IDUP) begin
				we = 1'b1;
				waddr = depth_q[AW-1:0];
				wdata = nxt;
			end
		end else if (ctl.div_wr) begin
			we = 1'b1;
			waddr = dm2[AW-1:0];
			wdata = qneg_q ? (32'd0 - quo_q) : quo_q;
		end else if (ctl.wr2) begin
			we = 1'b1;
			waddr = w2_addr_q;
			wdata = w2_data_q;
		end else if (ctl.sw_wr) begin
			we = 1'b1;
			waddr = lo_q;
			if (cmd_q == smx_pkg::OP_FLIP) wdata = nxt;
			else if (cmd_q == smx_pkg::OP_INCALL) wdata = top + 32'd1;
			else wdata = top - 32'd1;
		end else if (ctl.sw_wr2) begin
			we = 1'b1;
			waddr = hi_q;
			wdata = top;
		end
	end

	smx_ram #(
		.WIDTH(smx_pkg::WORD_W),
		.DEPTH(STACK_DEPTH)
	) u_stack_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.ren     (ren),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (top),
		.rdata_b (nxt)
	);

	assign stat.refuse = (st_dec != smx_pkg::ST_OK);
	assign stat.go_div = (cmd_q == smx_pkg::OP_DIV) && (nxt != '0);
	assign stat.go_wr2 = (cmd_q == smx_pkg::OP_SWAP) || (cmd_q == smx_pkg::OP_ISWAP);
	assign stat.go_sweep = ((cmd_q == smx_pkg::OP_INCALL || cmd_q == smx_pkg::OP_DECALL)
		&& !under1) || ((cmd_q == smx_pkg::OP_FLIP) && !under2);
	assign stat.is_flip = (cmd_q == smx_pkg::OP_FLIP);
	assign stat.div_last = (cnt_q == 5'd31);
	assign stat.more_incdec = (DW'(lo_q) + DW'(1)) < depth_q;
	assign stat.more_flip = (DW'(lo_q) + DW'(2)) < DW'(hi_q);
	assign stat.rsp_free = !rsp_valid_q || !rsp_stall;

	assign rsp_valid = rsp_valid_q;
	assign rsp_item = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			halted_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.exec) begin
				if (is_push || cmd_q == smx_pkg::OP_DUP || cmd_q == smx_pkg::OP_IDUP) begin
					depth_q <= depth_q + DW'(1);
				end else if (cmd_q == smx_pkg::OP_POP || cmd_q == smx_pkg::OP_PRINT
					|| is_arith_bin) begin
					depth_q <= dm1;
				end else if (cmd_q == smx_pkg::OP_POP2) begin
					depth_q <= dm2;
				end else if (cmd_q == smx_pkg::OP_CLEAR) begin
					depth_q <= '0;
				end
				if (cmd_q == smx_pkg::OP_STOP) begin
					halted_q <= 1'b1;
				end
			end else if (ctl.div_wr) begin
				depth_q <= dm1;
			end
			if (ctl.fin) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd_item.cmd;
			opnd_q <= cmd_item.operand;
		end
		if (ctl.dec) begin
			st_q <= st_dec;
			sv_q <= 1'b0;
			shown_q <= '0;
		end
		if (ctl.exec) begin
			if (cmd_q == smx_pkg::OP_PRINT || cmd_q == smx_pkg::OP_READ) begin
				sv_q <= 1'b1;
				shown_q <= top;
			end
			if (cmd_q == smx_pkg::OP_DIV && nxt == '0) begin
				st_q <= smx_pkg::ST_DIVZ;
			end
			// second write of a swap or index swap
			if (cmd_q == smx_pkg::OP_SWAP) begin
				w2_addr_q <= dm2[AW-1:0];
				w2_data_q <= top;
			end else begin
				w2_addr_q <= dm1[AW-1:0];
				w2_data_q <= nxt;
			end
			lo_q <= '0;
			hi_q <= dm1[AW-1:0];
			rem_q <= '0;
			quo_q <= top_abs;
			dvs_q <= nxt_abs;
			qneg_q <= top[31] ^ nxt[31];
			cnt_q <= '0;
		end
		if (ctl.div_step) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
			cnt_q <= cnt_q + 5'd1;
		end
		if (ctl.sw_wr && cmd_q != smx_pkg::OP_FLIP) begin
			lo_q <= lo_q + AW'(1);
		end
		if (ctl.sw_wr2) begin
			lo_q <= lo_q + AW'(1);
			hi_q <= hi_q - AW'(1);
		end
		if (ctl.fin) begin
			rsp_q.status <= st_q;
			rsp_q.shown_valid <= sv_q;
			rsp_q.shown_value <= shown_q;
			rsp_q.stack_depth <= 7'(depth_q);
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/stack_machine_execute_unit.sv =====
`default_nettype none
// Stack machine execute unit: each command transaction is one instruction on an operand
// stack of STACK_DEPTH signed 32-bit words held in a RAM with two read ports and one write
// port, and gives exactly one response transaction. Commands are taken one at a time,
// while an earlier response may still wait on its output register. An ordinary
// instruction passes from acceptance to response through register, decode and RAM read,
// execute and response load; swap and index swap add a step for their second RAM write;
// div adds its bit-serial divider, one quotient bit a cycle, then a quotient write;
// increment-all and decrement-all add a read and a write per word and flip a read and two
// writes per pair, limited by the single RAM write port. A refused instruction skips
// execute. Once stop has run, every command is refused with halted status until reset.
module stack_machine_execute_unit #(
	parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	output logic                     cmd_stall,
	input  wire smx_pkg::cmd_item_t  cmd_item,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output smx_pkg::rsp_item_t       rsp_item
);

	smx_pkg::dp_ctl_t  ctl;
	smx_pkg::dp_stat_t stat;
	logic              idle;

	assign cmd_stall = !idle;

	smx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.stat      (stat),
		.ctl       (ctl),
		.idle      (idle)
	);

	smx_dp #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_item  (cmd_item),
		.rsp_stall (rsp_stall),
		.ctl       (ctl),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_item  (rsp_item)
	);

endmodule
`default_nettype wire
